// ----- rtl/kdlp_pkg.sv -----
// kdlp_pkg: shared types and constants for the key debouncer with long-press detection.
// No dependencies. Imported by every kdlp_* module and the top level.
`default_nettype none

package kdlp_pkg;

  // Number of key fields on the ports (input bits and state outputs).
  localparam int unsigned KEY_FIELDS = 6;
  localparam int unsigned STATE_W    = 3;
  localparam int unsigned TIMER_W    = 13;
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // Configuration register widths
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned LONG_W     = 12;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd2;

  // Register reset values
  localparam logic [TICK_W-1:0]     TICK_MS_RST       = 8'd1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RST   = 10'd10;
  localparam logic [LONG_W-1:0]     LONG_PRESS_MS_RST = 12'd100;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE         = 3'd0,
    ST_DEBOUNCE     = 3'd1,
    ST_PRESS        = 3'd2,
    ST_HELD         = 3'd3,
    ST_LONG         = 3'd4,
    ST_RELEASE      = 3'd5,
    ST_LONG_RELEASE = 3'd6
  } kdlp_state_e;

  typedef struct packed {
    logic [TICK_W-1:0]     tick_ms;
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic [LONG_W-1:0]     long_press_ms;
  } kdlp_cfg_t;

  typedef struct packed {
    logic [KEY_FIELDS-1:0][STATE_W-1:0] state;
    logic [KEY_FIELDS-1:0]              raw;
  } kdlp_result_t;

endpackage

`default_nettype wire

// ----- rtl/key_debounce_long_press_top.sv -----
// key_debounce_long_press_top: six-key active-low debouncer with long-press detection.
// Depends on kdlp_pkg, kdlp_lane and kdlp_merge.
`default_nettype none

// Each input beat is one sampling tick carrying the raw levels of the keys
// (bit i is key i, 0 = pressed). One lane per key runs the seven-state machine
// (idle, debounce, press, held, long, release, long release) with a 13-bit
// timer that grows by tick_ms per tick and saturates at 8191. A press is taken
// once the timer exceeds debounce_ms; a hold turns long once it exceeds
// long_press_ms. All lanes update in the cycle the tick is accepted, so one
// tick is taken per clock while in_stall_o is low; the result beat (every key's
// new state plus the raw levels) is held in the output register. A skid stage
// lets a further tick in while the output is stalled; in_stall_o rises only when
// both the output register and the skid are full. Configuration (0 tick_ms,
// 1 debounce_ms, 2 long_press_ms; other indexes ignored) is written through
// cfg_we_i and should change only while no tick is in flight. Resets to
// tick 1 ms, debounce 10 ms, long press 100 ms.
module key_debounce_long_press_top #(
  parameter int unsigned NUM_KEYS = 6   // 1..32; keys past the input bits stay idle
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // tick input
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [kdlp_pkg::KEY_FIELDS-1:0]   key_levels_i,
  // result output
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [kdlp_pkg::STATE_W-1:0]      state_key0_o,
  output logic [kdlp_pkg::STATE_W-1:0]      state_key1_o,
  output logic [kdlp_pkg::STATE_W-1:0]      state_key2_o,
  output logic [kdlp_pkg::STATE_W-1:0]      state_key3_o,
  output logic [kdlp_pkg::STATE_W-1:0]      state_key4_o,
  output logic [kdlp_pkg::STATE_W-1:0]      state_key5_o,
  output logic [kdlp_pkg::KEY_FIELDS-1:0]   raw_levels_o,
  // configuration writes
  input  wire                               cfg_we_i,
  input  wire  [kdlp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [kdlp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import kdlp_pkg::*;

  kdlp_cfg_t    cfg_q, cfg_d;
  logic         in_accept;
  kdlp_state_e  lane_state [NUM_KEYS];
  kdlp_result_t result;

  assign in_accept = in_valid_i && !in_stall_o;

  // config registers; unknown index leaves everything as is
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICK_MS:       cfg_d.tick_ms       = cfg_wdata_i[TICK_W-1:0];
        REG_DEBOUNCE_MS:   cfg_d.debounce_ms   = cfg_wdata_i[DEBOUNCE_W-1:0];
        REG_LONG_PRESS_MS: cfg_d.long_press_ms = cfg_wdata_i[LONG_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms       <= TICK_MS_RST;
      cfg_q.debounce_ms   <= DEBOUNCE_MS_RST;
      cfg_q.long_press_ms <= LONG_PRESS_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // one lane per key; keys without an input bit never see a press
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pressed;
    if (k < KEY_FIELDS) begin : g_pin
      assign pressed = !key_levels_i[k];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    kdlp_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (in_accept),
      .pressed_i (pressed),
      .cfg_i     (cfg_q),
      .state_o   (lane_state[k])
    );
  end

  kdlp_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .lane_state_i (lane_state),
    .levels_i     (key_levels_i),
    .stall_o      (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (result)
  );

  assign state_key0_o = result.state[0];
  assign state_key1_o = result.state[1];
  assign state_key2_o = result.state[2];
  assign state_key3_o = result.state[3];
  assign state_key4_o = result.state[4];
  assign state_key5_o = result.state[5];
  assign raw_levels_o = result.raw;

endmodule

`default_nettype wire

// ----- rtl/kdlp_lane.sv -----
// kdlp_lane: one key's state machine and saturating elapsed-time counter.
// Depends on kdlp_pkg.
`default_nettype none

module kdlp_lane (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   adv_i,      // tick accepted
  input  wire                   pressed_i,
  input  kdlp_pkg::kdlp_cfg_t   cfg_i,
  output kdlp_pkg::kdlp_state_e state_o     // state after this tick
);
  import kdlp_pkg::*;

  kdlp_state_e        state_q, state_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] timer_inc;

  // saturating add of one tick
  assign sum       = {1'b0, timer_q} + {{(TIMER_W+1-TICK_W){1'b0}}, cfg_i.tick_ms};
  assign timer_inc = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];

  always_comb begin
    state_d = state_q;
    timer_d = timer_q;
    case (state_q)
      ST_DEBOUNCE: begin
        if (pressed_i) begin
          timer_d = timer_inc;
          if (timer_inc > {{(TIMER_W-DEBOUNCE_W){1'b0}}, cfg_i.debounce_ms}) begin
            state_d = ST_PRESS;
            timer_d = '0;
          end
        end else begin
          state_d = ST_IDLE;
          timer_d = '0;
        end
      end
      ST_PRESS: begin
        if (pressed_i) begin
          state_d = ST_HELD;
          timer_d = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_HELD: begin
        if (pressed_i) begin
          timer_d = timer_inc;
          if (timer_inc > {{(TIMER_W-LONG_W){1'b0}}, cfg_i.long_press_ms}) begin
            state_d = ST_LONG;
            timer_d = '0;
          end
        end else begin
          state_d = ST_RELEASE;
          timer_d = '0;
        end
      end
      ST_LONG: begin
        if (!pressed_i) begin
          state_d = ST_LONG_RELEASE;
        end
      end
      ST_RELEASE, ST_LONG_RELEASE: begin
        state_d = ST_IDLE;
      end
      default: begin  // idle, and the unused code
        if (pressed_i) begin
          state_d = ST_DEBOUNCE;
          timer_d = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      timer_q <= '0;
    end else if (adv_i) begin
      state_q <= state_d;
      timer_q <= timer_d;
    end
  end

  assign state_o = state_d;

`ifndef ASSERT_OFF
  // press is always entered with a cleared timer
  a_press_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRESS |-> timer_q == '0)
    else $error("kdlp_lane: timer not cleared in press state");
  // long hold is entered with a cleared timer and leaves it alone
  a_long_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LONG |-> timer_q == '0)
    else $error("kdlp_lane: timer not cleared in long state");
  // one-tick events last exactly one tick
  a_release_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && (state_q == ST_RELEASE || state_q == ST_LONG_RELEASE) |=> state_q == ST_IDLE)
    else $error("kdlp_lane: release event held longer than one tick");
`endif

endmodule

`default_nettype wire

// ----- rtl/kdlp_merge.sv -----
// kdlp_merge: gathers the lanes' new states and the raw levels into one result beat,
// held in an output register with a skid stage behind it. Depends on kdlp_pkg.
`default_nettype none

module kdlp_merge #(
  parameter int unsigned NUM_KEYS = 6
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,       // input beat accepted
  input  kdlp_pkg::kdlp_state_e  lane_state_i [NUM_KEYS],
  input  wire [kdlp_pkg::KEY_FIELDS-1:0] levels_i,
  output logic                   stall_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output kdlp_pkg::kdlp_result_t out_o
);
  import kdlp_pkg::*;

  kdlp_result_t res;
  kdlp_result_t out_q, out_d, skid_q, skid_d;
  logic         out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic         pop;

  // merge: keys past NUM_KEYS read as idle
  for (genvar k = 0; k < KEY_FIELDS; k++) begin : g_field
    if (k < NUM_KEYS) begin : g_key
      assign res.state[k] = lane_state_i[k];
    end else begin : g_none
      assign res.state[k] = ST_IDLE;
    end
  end
  assign res.raw = levels_i;

  assign pop     = out_valid_q && !out_stall_i;
  assign stall_o = skid_valid_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (load_i) begin
      if (!out_valid_q || pop) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("kdlp_merge: skid holds a beat while output is empty");
  a_no_load_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !skid_valid_q)
    else $error("kdlp_merge: beat loaded while skid is full");
  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && pop |=> out_valid_q && out_q == $past(skid_q))
    else $error("kdlp_merge: skid beat lost on drain");
`endif

endmodule

`default_nettype wire
